// ===== hdl/u8d_pkg.sv =====
package u8d_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 21;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned NUM_ST   = 9;
  localparam int unsigned NUM_CLS  = 12;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD_MASK    = 8'hFF;

  // States of the validation automaton.
  typedef enum logic [3:0] {
    S_ACCEPT    = 4'd0,
    S_REJECT    = 4'd1,
    S_CONT1     = 4'd2,
    S_CONT2     = 4'd3,
    S_AFTER_E0  = 4'd4,
    S_AFTER_ED  = 4'd5,
    S_AFTER_F0  = 4'd6,
    S_CONT3     = 4'd7,
    S_AFTER_F4  = 4'd8
  } dfa_state_t;

  // Byte classes.
  typedef enum logic [3:0] {
    CLS_ASCII    = 4'd0,
    CLS_CONT_LO  = 4'd1,
    CLS_LEAD2    = 4'd2,
    CLS_LEAD3    = 4'd3,
    CLS_LEAD_ED  = 4'd4,
    CLS_LEAD_F4  = 4'd5,
    CLS_LEAD4    = 4'd6,
    CLS_CONT_HI  = 4'd7,
    CLS_INVALID  = 4'd8,
    CLS_CONT_MID = 4'd9,
    CLS_LEAD_E0  = 4'd10,
    CLS_LEAD_F0  = 4'd11
  } byte_class_t;

  // One classified byte as it waits between the front and the back.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              buffer_start;
    byte_class_t       cls;
  } q_item_t;

  // Next state, indexed by [state][class].
  localparam logic [3:0] NEXT_TABLE [0:NUM_ST-1][0:NUM_CLS-1] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // Maps a raw byte to its class.
  function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    if (b <= 8'h7F) begin
      c = CLS_ASCII;
    end else if (b <= 8'h8F) begin
      c = CLS_CONT_LO;
    end else if (b <= 8'h9F) begin
      c = CLS_CONT_MID;
    end else if (b <= 8'hBF) begin
      c = CLS_CONT_HI;
    end else if (b <= 8'hC1) begin
      c = CLS_INVALID;
    end else if (b <= 8'hDF) begin
      c = CLS_LEAD2;
    end else if (b == 8'hE0) begin
      c = CLS_LEAD_E0;
    end else if (b == 8'hED) begin
      c = CLS_LEAD_ED;
    end else if (b <= 8'hEF) begin
      c = CLS_LEAD3;
    end else if (b == 8'hF0) begin
      c = CLS_LEAD_F0;
    end else if (b <= 8'hF3) begin
      c = CLS_LEAD4;
    end else if (b == 8'hF4) begin
      c = CLS_LEAD_F4;
    end else begin
      c = CLS_INVALID;
    end
    return c;
  endfunction

  // Transition lookup; state codes past the table act as reject.
  function automatic dfa_state_t next_state(input dfa_state_t st, input byte_class_t c);
    logic [3:0] row;
    logic [3:0] col;
    row = (st >= dfa_state_t'(NUM_ST)) ? S_REJECT : st;
    col = (c >= byte_class_t'(NUM_CLS)) ? CLS_INVALID : c;
    return dfa_state_t'(NEXT_TABLE[row][col]);
  endfunction

endpackage

// ===== hdl/utf8_stream_decoder.sv =====
// Channel   Direction  tdata               tuser
// in_       slave      [7:0] byte_value    [0] buffer_start
// out_      master     [20:0] scalar value none
//
// Each byte is classified in the front and written to a four-entry queue; in the
// back the automaton and accumulator advance. Sustained rate is one byte per
// cycle while out_tready does not stall a valid output register.
// rst_n (synchronous) returns the automaton to accept and empties the queue.
// A stall on out_tready holds the output register; the queue absorbs up to four
// further bytes before in_tready falls.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] buffer_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [20:0] scalar value, [23:21] zero
);
  import u8d_pkg::*;

  logic    q_full, q_push, q_pop, q_not_empty;
  q_item_t push_item, head_item;

  // Front: accept and classify.
  u8d_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Queue between front and back.
  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back: automaton, accumulator and output register.
  u8d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== hdl/u8d_front.sv =====
module u8d_front (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] byte_value
  input  logic                       in_tuser,   // [0] buffer_start
  input  logic                       q_full,
  output logic                       q_push,
  output u8d_pkg::q_item_t           q_item
);
  import u8d_pkg::*;

  // Accept a transfer whenever the queue has room.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify the byte on the way into the queue.
  always_comb begin
    q_item.byte_value   = in_tdata;
    q_item.buffer_start = in_tuser;
    q_item.cls          = classify(in_tdata);
  end

endmodule

// ===== hdl/u8d_queue.sv =====
module u8d_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8d_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output u8d_pkg::q_item_t head_item
);
  import u8d_pkg::*;

  q_item_t              slots_r [0:Q_DEPTH-1];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slots_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && not_empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/u8d_back.sv =====
module u8d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  u8d_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata    // [20:0] scalar value, [23:21] zero
);
  import u8d_pkg::*;

  dfa_state_t          state_r, state_nxt, cur_state;
  logic [CODE_W-1:0]   partial_r, partial_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   out_code_r;
  logic                take;
  logic                emit;
  logic [BYTE_W-1:0]   lead_bits;

  // Take the next queued byte when the output register is free or drains now.
  assign take  = q_not_empty && (!out_valid_r || out_tready);
  assign q_pop = take;

  // A buffer start puts the automaton back to accept before this byte.
  assign cur_state = q_item.buffer_start ? S_ACCEPT : state_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (take) begin
      state_nxt = next_state(cur_state, q_item.cls);
    end
  end

  // Accumulator, emit flag and output register control.
  always_comb begin
    lead_bits   = (LEAD_MASK >> q_item.cls) & q_item.byte_value;
    partial_nxt = partial_r;
    emit        = 1'b0;
    if (take) begin
      if (cur_state != S_ACCEPT) begin
        partial_nxt = {partial_r[CODE_W-7:0], 6'b0}
                      | CODE_W'(q_item.byte_value & PAYLOAD_MASK);
      end else begin
        partial_nxt = CODE_W'(lead_bits);
      end
      emit = (next_state(cur_state, q_item.cls) == S_ACCEPT);
    end
    if (take) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCEPT;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload is loaded only when a code point completes.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_code_r <= partial_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - CODE_W)'(0), out_code_r};

endmodule
